FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge, quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CHK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/wsst_pkg.sv
package wsst_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int DAYS_PER_WEEK   = 7;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [1:0] AUTO_MODE = 2'd2;

   localparam logic [2:0] REQ_CLEAR    = 3'd0;
   localparam logic [2:0] REQ_INSERT   = 3'd1;
   localparam logic [2:0] REQ_NORMAL   = 3'd2;
   localparam logic [2:0] REQ_AUTO     = 3'd3;
   localparam logic [2:0] REQ_RESUME   = 3'd4;
   localparam logic [2:0] REQ_OPPOSITE = 3'd5;

   localparam logic CSR_IDX_MODE = 1'b0;

   typedef logic [14:0] entry_type;

endpackage

FILE: rtl/weekly_switch_schedule_table.sv
// Weekly switch schedule table.
// Input channel (req_*): one request per beat: clear, insert, normalize, auto check,
// resume last, opposite next. Result channel (rsp_*): exactly one beat per request.
// Both channels use valid/stall; a beat moves when valid is high and stall is low.
// Entries live in one single-port-write memory with a registered read;
// every scan walks it one entry per cycle.
// Clear, rejected and trivial requests go straight to the done state and the result register;
// insert scans down from the top, shifting as it goes, and stops once its slot is found;
// normalize and the three queries scan every stored entry.
// One request is in flight at a time; a new one is taken once the previous result
// sits in the output register, so no request is taken before the last one is through.
// Reset empties the table and sets relay_mode to 0; memory contents are not cleared.
// If the receiver stalls, the result holds in the output register and the block
// finishes its next request, then waits with it until the output frees up.
// relay_mode lives at byte address 0 of the APB-style csr port.
module weekly_switch_schedule_table #(
   parameter int MAX_ENTRIES = wsst_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_req_type,
   input  logic [2:0]                          req_ev_day,
   input  logic [4:0]                          req_ev_hour,
   input  logic [5:0]                          req_ev_minute,
   input  logic                                req_ev_state,
   input  logic                                req_time_valid,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drive_valid,
   output logic                                rsp_drive_state,
   output logic [2:0]                          rsp_found_day,
   output logic [4:0]                          rsp_found_hour,
   output logic [5:0]                          rsp_found_minute,
   output logic [6:0]                          rsp_entry_count,
   output logic                                rsp_table_full,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wsst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wsst_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wsst_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import wsst_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] ONE_CNT  = CW'(1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INS  = 3'd1;
   localparam logic [2:0] ST_INS0 = 3'd2;
   localparam logic [2:0] ST_NORM = 3'd3;
   localparam logic [2:0] ST_SRCH = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   entry_type mem [MAX_ENTRIES];
   entry_type rdata_ff;

   logic [2:0]    st_ff, st_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [2:0]    op_ff, op_in;
   entry_type     ne_ff, ne_in;
   logic [2:0]    cur_ff, cur_in;
   logic          full_ff, full_in;
   logic          have_ff, have_in;
   logic [2:0]    lday_ff, lday_in;
   logic          lst_ff, lst_in;
   logic          bvld_ff, bvld_in;
   logic [2:0]    bd_ff, bd_in;
   entry_type     be_ff, be_in;

   logic          rv_ff, rv_in;
   logic          rdv_ff, rdv_in;
   logic          rds_ff, rds_in;
   logic [2:0]    rday_ff, rday_in;
   logic [4:0]    rhour_ff, rhour_in;
   logic [5:0]    rmin_ff, rmin_in;
   logic [6:0]    rcnt_ff, rcnt_in;
   logic          rfull_ff, rfull_in;

   logic          we;
   logic [AW-1:0] wa;
   entry_type     wd;
   logic          accept, iss, last, cand, better;
   logic [3:0]    diff;
   logic [2:0]    span;
   logic [10:0]   t_e, t_now;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (st_ff != ST_IDLE);
   assign iss        = (st_ff == ST_INS || st_ff == ST_NORM || st_ff == ST_SRCH)
                       && (rem_ff != '0);
   assign last       = (rd_idx_ff == total_ff - ONE_CNT);
   assign t_e        = rdata_ff[11:1];
   assign t_now      = ne_ff[11:1];

   always_comb begin
      if (op_ff == REQ_OPPOSITE) begin
         diff = {1'b0, rdata_ff[14:12]} - {1'b0, cur_ff};
      end else begin
         diff = {1'b0, cur_ff} - {1'b0, rdata_ff[14:12]};
      end
      span = diff[3] ? 3'(diff + 4'd7) : diff[2:0];
      cand = (rdata_ff[14:12] != 3'd7);
      if (op_ff == REQ_OPPOSITE) begin
         if (span == 3'd0 && t_e <= t_now) cand = 1'b0;
      end else begin
         if (span == 3'd0 && t_e > t_now) cand = 1'b0;
         if (op_ff == REQ_AUTO && span != 3'd0) cand = 1'b0;
      end
      if (!bvld_ff || span < bd_ff) begin
         better = 1'b1;
      end else if (span == bd_ff) begin
         better = (op_ff == REQ_OPPOSITE) ? (t_e < be_ff[11:1]) : (t_e > be_ff[11:1]);
      end else begin
         better = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;   mode_in = mode_ff; total_in = total_ff;
      idx_in = idx_ff; rem_in = rem_ff;   k_in = k_ff;
      rd_vld_in = iss; rd_idx_in = idx_ff;
      op_in = op_ff;   ne_in = ne_ff;     cur_in = cur_ff;  full_in = full_ff;
      have_in = have_ff; lday_in = lday_ff; lst_in = lst_ff;
      bvld_in = bvld_ff; bd_in = bd_ff;   be_in = be_ff;
      rv_in = rv_ff;   rdv_in = rdv_ff;   rds_in = rds_ff;  rday_in = rday_ff;
      rhour_in = rhour_ff; rmin_in = rmin_ff; rcnt_in = rcnt_ff; rfull_in = rfull_ff;
      we = 1'b0; wa = '0; wd = ne_ff;

      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_IDX_MODE) begin
         mode_in = csr_pwdata[1:0];
      end
      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      if (iss) begin
         rem_in = rem_ff - ONE_CNT;
         idx_in = (st_ff == ST_INS) ? idx_ff - ONE_CNT : idx_ff + ONE_CNT;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_req_type;
               ne_in   = {req_ev_day, req_ev_hour, req_ev_minute, req_ev_state};
               cur_in  = (req_ev_day == 3'd7) ? 3'd0 : req_ev_day;
               full_in = 1'b0;
               bvld_in = 1'b0; bd_in = '0; be_in = '0;
               have_in = 1'b0; k_in = '0;
               st_in   = ST_DONE;
               unique case (req_req_type) inside
                  REQ_CLEAR: total_in = '0;
                  REQ_INSERT: begin
                     if (total_ff == FULL_CNT) begin
                        full_in = 1'b1;
                     end else if (total_ff == '0) begin
                        we = 1'b1; wa = '0;
                        wd = {req_ev_day, req_ev_hour, req_ev_minute, req_ev_state};
                        total_in = ONE_CNT;
                     end else begin
                        st_in = ST_INS; idx_in = total_ff - ONE_CNT; rem_in = total_ff;
                     end
                  end
                  REQ_NORMAL: begin
                     if (total_ff > ONE_CNT) begin
                        st_in = ST_NORM; idx_in = '0; rem_in = total_ff;
                     end
                  end
                  REQ_AUTO, REQ_RESUME, REQ_OPPOSITE: begin
                     if (req_time_valid && total_ff != '0 &&
                         (req_req_type != REQ_AUTO || mode_ff == AUTO_MODE)) begin
                        st_in = ST_SRCH; idx_in = '0; rem_in = total_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS: begin
            if (rd_vld_ff) begin
               we = 1'b1;
               wa = AW'(rd_idx_ff + ONE_CNT);
               if (rdata_ff[14:1] > ne_ff[14:1]) begin
                  wd = rdata_ff;
                  if (rd_idx_ff == '0) begin
                     st_in = ST_INS0; rem_in = '0;
                  end
               end else begin
                  wd = ne_ff; total_in = total_ff + ONE_CNT;
                  st_in = ST_DONE; rem_in = '0;
               end
            end
         end
         ST_INS0: begin
            we = 1'b1; wa = '0; wd = ne_ff;
            total_in = total_ff + ONE_CNT;
            st_in = ST_DONE;
         end
         ST_NORM: begin
            if (rd_vld_ff) begin
               wa = k_ff[AW-1:0]; wd = rdata_ff;
               if (!have_ff || rdata_ff[14:12] != lday_ff) begin
                  we = 1'b1; have_in = 1'b1; lday_in = rdata_ff[14:12];
                  lst_in = rdata_ff[0];
               end else if (rdata_ff[0] != lst_ff) begin
                  we = 1'b1; lst_in = rdata_ff[0];
               end
               if (we) k_in = k_ff + ONE_CNT;
               if (last) begin
                  total_in = k_in; st_in = ST_DONE;
               end
            end
         end
         ST_SRCH: begin
            if (rd_vld_ff) begin
               if (cand && better) begin
                  bvld_in = 1'b1; bd_in = span; be_in = rdata_ff;
               end
               if (last) st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               rdv_in   = bvld_ff;
               rds_in   = bvld_ff & (be_ff[0] ^ (op_ff == REQ_OPPOSITE));
               rday_in  = bvld_ff ? be_ff[14:12] : 3'd0;
               rhour_in = bvld_ff ? be_ff[11:7] : 5'd0;
               rmin_in  = bvld_ff ? be_ff[6:1] : 6'd0;
               rcnt_in  = 7'(total_ff);
               rfull_in = full_ff;
               st_in    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         mode_ff <= '0;
         total_ff <= '0;
         rem_ff <= '0;
         rd_vld_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         mode_ff <= mode_in;
         total_ff <= total_in;
         rem_ff <= rem_in;
         rd_vld_ff <= rd_vld_in;
         rv_ff <= rv_in;
      end
      idx_ff <= idx_in;     k_ff <= k_in;       rd_idx_ff <= rd_idx_in;
      op_ff <= op_in;       ne_ff <= ne_in;     cur_ff <= cur_in;
      full_ff <= full_in;   have_ff <= have_in; lday_ff <= lday_in;
      lst_ff <= lst_in;     bvld_ff <= bvld_in; bd_ff <= bd_in;
      be_ff <= be_in;       rdv_ff <= rdv_in;   rds_ff <= rds_in;
      rday_ff <= rday_in;   rhour_ff <= rhour_in; rmin_ff <= rmin_in;
      rcnt_ff <= rcnt_in;   rfull_ff <= rfull_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_drive_valid  = rdv_ff;
   assign rsp_drive_state  = rds_ff;
   assign rsp_found_day    = rday_ff;
   assign rsp_found_hour   = rhour_ff;
   assign rsp_found_minute = rmin_ff;
   assign rsp_entry_count  = rcnt_ff;
   assign rsp_table_full   = rfull_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == CSR_IDX_MODE) ?
                             {{(CSR_DATA_W-2){1'b0}}, mode_ff} : '0;

endmodule

FILE: rtl/wsst_checker.sv
`include "assert_macros.svh"

module wsst_checker #(
   parameter int MAX_ENTRIES = wsst_pkg::MAX_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_drive_valid,
   input logic       rsp_drive_state,
   input logic [2:0] rsp_found_day,
   input logic [4:0] rsp_found_hour,
   input logic [5:0] rsp_found_minute,
   input logic [6:0] rsp_entry_count,
   input logic       rsp_table_full
);
   import wsst_pkg::*;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_count) && $stable(rsp_drive_state), "stalled result changed")
   `CHK_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "second request taken while busy")
   `CHK_IMPL(a_full_no_drive, clock, reset, rsp_valid && rsp_table_full |-> !rsp_drive_valid, "full insert drove switch")
   `CHK_IMPL(a_idle_zero, clock, reset, rsp_valid && !rsp_drive_valid |-> rsp_found_day == 3'd0 && rsp_found_hour == 5'd0 && rsp_found_minute == 6'd0 && !rsp_drive_state, "undriven result not zero")
   `CHK_IMPL(a_count_max, clock, reset, rsp_valid |-> 32'(rsp_entry_count) <= MAX_ENTRIES, "entry count above capacity")

endmodule

bind weekly_switch_schedule_table wsst_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_wsst_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_drive_valid(rsp_drive_valid),
   .rsp_drive_state(rsp_drive_state), .rsp_found_day(rsp_found_day),
   .rsp_found_hour(rsp_found_hour), .rsp_found_minute(rsp_found_minute),
   .rsp_entry_count(rsp_entry_count), .rsp_table_full(rsp_table_full)
);
